### design/color_histogram_percent_unit_assert.svh
// Assertion macros for the color histogram percent unit.
`ifndef COLOR_HISTOGRAM_PERCENT_UNIT_ASSERT_SVH
`define COLOR_HISTOGRAM_PERCENT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clock edge outside reset.
`define CHP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHP_ASSERT_IMPL(lbl, ante, cons)
`define CHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/chp_pkg.sv
// Shared types, constants and functions of the color histogram unit.
`default_nettype none
package chp_pkg;

    localparam int NUM_BINS  = 64;
    localparam int BIN_BITS  = 6;
    localparam int PCT_BITS  = 7;
    localparam int CHAN_BITS = 8;

    // One classified pixel as it travels from front end to back end.
    typedef struct packed {
        logic [BIN_BITS-1:0] bin;
        logic                last;
    } t_item;

    // Top two bits of each channel give its region; red is most significant.
    function automatic logic [BIN_BITS-1:0] bin_of(
        input logic [CHAN_BITS-1:0] red,
        input logic [CHAN_BITS-1:0] green,
        input logic [CHAN_BITS-1:0] blue
    );
        bin_of = {red[CHAN_BITS-1 -: 2], green[CHAN_BITS-1 -: 2], blue[CHAN_BITS-1 -: 2]};
    endfunction

endpackage
`default_nettype wire

### design/chp_front.sv
// Front end: takes pixel beats and registers their bin index and end marker.
`default_nettype none
module chp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_red,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_green,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_blue,
    input  wire logic                          i_last_pixel,
    output logic                               o_item_valid,
    input  wire logic                          i_item_ready,
    output chp_pkg::t_item                     o_item
);
    import chp_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_ready      = !r_vld || i_item_ready;
    assign o_item_valid = r_vld;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.bin  <= bin_of(i_red, i_green, i_blue);
            r_item.last <= i_last_pixel;
        end
    end

endmodule
`default_nettype wire

### design/chp_queue.sv
// Four-entry queue of classified pixels between front and back end.
`default_nettype none
module chp_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  chp_pkg::t_item i_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output chp_pkg::t_item o_item
);
    import chp_pkg::*;

    localparam int DEPTH  = 4;
    localparam int AW     = $clog2(DEPTH);

    t_item         r_buf [DEPTH];
    logic [AW:0]   r_wr_ptr;
    logic [AW:0]   r_rd_ptr;
    logic          full;
    logic          empty;
    logic          push;
    logic          pop;

    assign empty        = (r_wr_ptr == r_rd_ptr);
    assign full         = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) && (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign o_item       = r_buf[r_rd_ptr[AW-1:0]];
    assign push         = i_push_valid && !full;
    assign pop          = i_pop_ready && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr[AW-1:0]] <= i_item;
        end
    end

endmodule
`default_nettype wire

### design/chp_back.sv
// Back end: bin counter memory, pixel total and the per-bin percent read-out.
`default_nettype none
module chp_back #(
    parameter int COUNT_BITS = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_item_valid,
    output logic                              o_item_ready,
    input  chp_pkg::t_item                    i_item,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [chp_pkg::BIN_BITS-1:0]      o_bin_index,
    output logic [chp_pkg::PCT_BITS-1:0]      o_percent,
    output logic                              o_last_bin
);
    import chp_pkg::*;

    localparam int W = COUNT_BITS + PCT_BITS;   // holds 100 * count

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_PUT   = 3'd4;

    localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(NUM_BINS - 1);
    localparam logic [2:0]          LAST_STEP = 3'(PCT_BITS - 1);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_vld;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_rd_vld;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    // accumulate pipeline
    logic                  r_s2_vld;
    logic [BIN_BITS-1:0]   r_s2_bin;
    logic                  r_s2_last;
    logic                  r_wr_vld;
    logic [BIN_BITS-1:0]   r_wr_bin;
    logic [COUNT_BITS-1:0] r_wr_cnt;
    logic [COUNT_BITS-1:0] r_total;

    // read-out
    logic [BIN_BITS-1:0]   r_ro_bin;
    logic [W-1:0]          r_rem;
    logic [W-1:0]          r_dsh;
    logic [PCT_BITS-1:0]   r_quo;
    logic [2:0]            r_step;

    logic                  pop;
    logic [BIN_BITS-1:0]   rd_addr;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [W-1:0]          cnt_w;
    logic                  ge;
    logic                  out_free;

    assign o_item_ready = (r_state == ST_ACC) && !(r_s2_vld && r_s2_last);
    assign pop          = o_item_ready && i_item_valid;
    assign rd_addr      = (r_state == ST_ACC) ? i_item.bin : r_ro_bin;

    // Forward the count written last cycle, the memory still shows the old one.
    always_comb begin
        if (r_wr_vld && (r_wr_bin == r_s2_bin)) begin
            old_cnt = r_wr_cnt;
        end else if (r_rd_vld) begin
            old_cnt = r_rd_cnt;
        end else begin
            old_cnt = '0;
        end
        new_cnt = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
    end

    assign cnt_rd   = r_rd_vld ? r_rd_cnt : '0;
    assign cnt_w    = W'(cnt_rd);
    assign ge       = (r_rem >= r_dsh);
    assign out_free = !o_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    n_state = (r_ro_bin == LAST_BIN) ? ST_ACC : ST_ISSUE;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    // counter memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        r_rd_cnt <= r_mem[rd_addr];
        if (r_state == ST_ACC && r_s2_vld) begin
            r_mem[r_s2_bin] <= new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ACC;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_total  <= '0;
            r_ro_bin <= '0;
            r_step   <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_vld[rd_addr];
            r_s2_vld <= pop;
            if (r_state == ST_ACC && r_s2_vld) begin
                r_vld[r_s2_bin] <= 1'b1;
                r_total         <= (&r_total) ? r_total : r_total + COUNT_BITS'(1);
                r_wr_vld        <= !r_s2_last;
                if (r_s2_last) begin
                    r_ro_bin <= '0;
                end
            end else begin
                r_wr_vld <= 1'b0;
            end
            if (r_state == ST_LOAD) begin
                r_step <= '0;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step + 3'd1;
            end
            if (r_state == ST_PUT && out_free) begin
                o_valid  <= 1'b1;
                r_ro_bin <= r_ro_bin + 1'b1;
                if (r_ro_bin == LAST_BIN) begin
                    r_vld   <= '0;
                    r_total <= '0;
                end
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s2_bin  <= i_item.bin;
            r_s2_last <= i_item.last;
        end
        if (r_state == ST_ACC && r_s2_vld) begin
            r_wr_bin <= r_s2_bin;
            r_wr_cnt <= new_cnt;
        end
        // restoring division, one quotient bit per cycle, MSB first
        if (r_state == ST_LOAD) begin
            r_rem <= (cnt_w << 6) + (cnt_w << 5) + (cnt_w << 2);
            r_dsh <= (r_total == '0) ? '1 : (W'(r_total) << (PCT_BITS - 1));
            r_quo <= '0;
        end else if (r_state == ST_DIV) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[PCT_BITS-2:0], ge};
        end
        if (r_state == ST_PUT && out_free) begin
            o_bin_index <= r_ro_bin;
            o_percent   <= r_quo;
            o_last_bin  <= (r_ro_bin == LAST_BIN);
        end
    end

endmodule
`default_nettype wire

### design/color_histogram_percent_unit.sv
// Top level of the 64-bin quantized RGB histogram with percent read-out.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+------------------------------------------
//  pixel in | i_valid / o_ready  | i_red, i_green, i_blue, i_last_pixel
//  bin out  | o_valid / i_ready  | o_bin_index, o_percent, o_last_bin
//
// Pixels go in one per cycle while the back end accumulates: the front end
// registers the bin index, a four-entry queue feeds the back end, which
// read-modify-writes the counter memory each cycle. A beat marked last starts the
// read-out: per bin one read, one load, a restoring divide and one output beat;
// pixels fill the queue meanwhile and then see o_ready low. Synchronous active-low
// reset clears control and per-bin valid bits; a stalled output holds its beat.
`default_nettype none
`include "color_histogram_percent_unit_assert.svh"
module color_histogram_percent_unit #(
    parameter int COUNT_BITS = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_red,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_green,
    input  wire logic [chp_pkg::CHAN_BITS-1:0] i_blue,
    input  wire logic                          i_last_pixel,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [chp_pkg::BIN_BITS-1:0]       o_bin_index,
    output logic [chp_pkg::PCT_BITS-1:0]       o_percent,
    output logic                               o_last_bin
);
    import chp_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  front_valid;
    logic  front_ready;
    logic  queue_valid;
    logic  queue_ready;

    chp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    chp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_item       (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_item       (queue_item)
    );

    chp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bin_index  (o_bin_index),
        .o_percent    (o_percent),
        .o_last_bin   (o_last_bin)
    );

    // end-of-run flag only on the final bin
    `CHP_ASSERT_IMPL(a_last_bin_is_63, o_valid && o_last_bin, o_bin_index == 6'd63)
    // saturation keeps every bin count at or below the total
    `CHP_ASSERT_IMPL(a_percent_range, o_valid, o_percent <= 7'd100)
    // a new run cannot follow the final bin in the next cycle
    `CHP_ASSERT_NEXT(a_run_gap, o_valid && i_ready && o_last_bin, !o_valid)

endmodule
`default_nettype wire
